// ----- rtl/sfr_pkg.sv -----
package sfr_pkg;

    localparam logic [7:0] SYNC_FIRST  = 8'hAA;
    localparam logic [7:0] SYNC_SECOND = 8'h55;

    // Payload bytes per frame; the checksum byte follows them.
    localparam int PAYLOAD_LEN = 12;
    localparam int IDX_W       = $clog2(PAYLOAD_LEN + 1);

    localparam int QUEUE_DEPTH_DEF = 4;

    typedef enum logic [1:0] {
        HUNT_FIRST  = 2'd0,
        HUNT_SECOND = 2'd1,
        COLLECT     = 2'd2
    } t_hunt;

    // One classified frame byte passed from the front to the back.
    typedef struct packed {
        logic             last;   // checksum byte, closes the frame
        logic [IDX_W-1:0] idx;    // payload position
        logic [7:0]       data;
    } t_beat;

    function automatic logic [7:0] reset_pattern_byte(input logic [IDX_W-1:0] idx);
        logic [7:0] val;
        val = 8'h00;
        case (idx)
            IDX_W'(0):  val = 8'h11;
            IDX_W'(1):  val = 8'h22;
            IDX_W'(2):  val = 8'h33;
            IDX_W'(3):  val = 8'h44;
            IDX_W'(4):  val = 8'h55;
            IDX_W'(5):  val = 8'h66;
            IDX_W'(6):  val = 8'h77;
            IDX_W'(7):  val = 8'h88;
            IDX_W'(8):  val = 8'h99;
            IDX_W'(9):  val = 8'hAA;
            IDX_W'(10): val = 8'hBB;
            IDX_W'(11): val = 8'hCC;
            default:    val = 8'h00;
        endcase
        return val;
    endfunction

endpackage

// ----- rtl/sfr_front.sv -----
module sfr_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic [7:0]    i_rx_byte,
    output logic          o_push,
    output sfr_pkg::t_beat o_beat
);
    import sfr_pkg::*;

    t_hunt             r_state, n_state;
    logic [IDX_W-1:0]  r_count, n_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= HUNT_FIRST;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        o_push      = 1'b0;
        o_beat.last = (r_count == IDX_W'(PAYLOAD_LEN));
        o_beat.idx  = r_count;
        o_beat.data = i_rx_byte;
        unique case (r_state)
            HUNT_FIRST: begin
                if (i_accept && i_rx_byte == SYNC_FIRST) begin
                    n_state = HUNT_SECOND;
                end
            end
            HUNT_SECOND: begin
                if (i_accept) begin
                    n_state = (i_rx_byte == SYNC_SECOND) ? COLLECT : HUNT_FIRST;
                end
            end
            COLLECT: begin
                if (i_accept) begin
                    o_push = 1'b1;
                    if (o_beat.last) begin
                        n_state = HUNT_FIRST;
                        n_count = '0;
                    end else begin
                        n_count = r_count + 1'b1;
                    end
                end
            end
            default: begin
                n_state = HUNT_FIRST;
                n_count = '0;
            end
        endcase
    end

endmodule

// ----- rtl/sfr_queue.sv -----
module sfr_queue #(
    parameter int DEPTH = sfr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  sfr_pkg::t_beat i_beat,
    output logic           o_full,
    output logic           o_valid,
    input  logic           i_pop,
    output sfr_pkg::t_beat o_beat
);
    import sfr_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_beat              r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr, n_wr;
    logic [PTR_W-1:0]   r_rd, n_rd;
    logic [CNT_W-1:0]   r_count, n_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_beat  = r_mem[r_rd];

    always_comb begin
        n_wr = r_wr;
        n_rd = r_rd;
        if (i_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        unique case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_beat;
        end
    end

`ifndef SYNTHESIS
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("queue written while full");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("queue read while empty");
`endif

endmodule

// ----- rtl/sfr_back.sv -----
module sfr_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic           i_cfg_wdata,
    input  logic           i_q_valid,
    input  sfr_pkg::t_beat i_beat,
    output logic           o_pop,
    output logic           o_res_valid,
    input  logic           i_res_ready,
    output logic           o_status,
    output logic           o_velocity_valid,
    output logic [31:0]    o_forward_speed_bits,
    output logic [31:0]    o_sideways_speed_bits,
    output logic [31:0]    o_turn_rate_bits,
    output logic           o_reset_request
);
    import sfr_pkg::*;

    logic        r_mode;
    logic [7:0]  r_sum;
    logic        r_match;
    logic [7:0]  r_store [PAYLOAD_LEN];
    logic        r_out_valid;
    logic        r_status;
    logic        r_vel;
    logic [31:0] r_fwd;
    logic [31:0] r_side;
    logic [31:0] r_turn;
    logic        r_rst_req;

    logic good;
    logic vel;

    // A payload byte never waits; the checksum byte waits for a free output register.
    assign o_pop = i_q_valid && (!i_beat.last || !r_out_valid || i_res_ready);
    assign good  = (i_beat.data == r_sum);
    assign vel   = good && r_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= 1'b0;
            r_sum       <= '0;
            r_match     <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end
            if (o_pop && !i_beat.last) begin
                r_sum <= r_sum + i_beat.data;
                if (i_beat.data != reset_pattern_byte(i_beat.idx)) begin
                    r_match <= 1'b0;
                end
            end
            if (o_pop && i_beat.last) begin
                r_sum       <= '0;
                r_match     <= 1'b1;
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && !i_beat.last) begin
            r_store[i_beat.idx] <= i_beat.data;
        end
        if (o_pop && i_beat.last) begin
            r_status  <= !good;
            r_vel     <= vel;
            r_rst_req <= good && r_match;
            r_fwd     <= vel ? {r_store[3], r_store[2], r_store[1], r_store[0]} : '0;
            r_side    <= vel ? {r_store[7], r_store[6], r_store[5], r_store[4]} : '0;
            r_turn    <= vel ? {r_store[11], r_store[10], r_store[9], r_store[8]} : '0;
        end
    end

    assign o_res_valid           = r_out_valid;
    assign o_status              = r_status;
    assign o_velocity_valid      = r_vel;
    assign o_forward_speed_bits  = r_fwd;
    assign o_sideways_speed_bits = r_side;
    assign o_turn_rate_bits      = r_turn;
    assign o_reset_request       = r_rst_req;

`ifndef SYNTHESIS
    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_beat.last) |-> (!r_out_valid || i_res_ready))
        else $error("result overwritten before it was taken");
    a_words_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !o_velocity_valid) |->
        (o_forward_speed_bits == '0 && o_sideways_speed_bits == '0 &&
         o_turn_rate_bits == '0))
        else $error("speed words not cleared without velocity");
    a_good_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_status) |-> (!o_velocity_valid && !o_reset_request))
        else $error("flags raised on a bad frame");
`endif

endmodule

// ----- rtl/sync_sum_frame_receiver.sv -----
// A frame's result is registered in the back once its checksum beat leaves the queue;
// beats still queued ahead of it, or a previous result not yet taken, hold it back.
// Throughput: one byte beat per cycle, sustained while the queue is not full.
// The result register frees the queue so bytes keep flowing while a result waits.
// Reset: synchronous, active low; hunt returns to the first sync byte, the mode register
// clears, the queue empties and any pending result is dropped.
module sync_sum_frame_receiver #(
    parameter int QUEUE_DEPTH = sfr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        i_rx_valid,
    output logic        o_rx_ready,
    input  logic [7:0]  i_rx_byte,
    output logic        o_res_valid,
    input  logic        i_res_ready,
    output logic        o_status,
    output logic        o_velocity_valid,
    output logic [31:0] o_forward_speed_bits,
    output logic [31:0] o_sideways_speed_bits,
    output logic [31:0] o_turn_rate_bits,
    output logic        o_reset_request
);
    import sfr_pkg::*;

    // The front hunts for the sync header and tags each frame byte with its
    // position. Header bytes are consumed there; only payload and checksum
    // beats enter the queue.
    logic  accept;
    logic  push;
    t_beat push_beat;
    logic  q_full;
    logic  q_valid;
    logic  pop;
    t_beat pop_beat;

    // A byte is taken whenever the queue has room, even while a finished
    // result still waits to be collected downstream.
    assign o_rx_ready = !q_full;
    assign accept     = i_rx_valid && o_rx_ready;

    sfr_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_rx_byte (i_rx_byte),
        .o_push    (push),
        .o_beat    (push_beat)
    );

    // The queue decouples the two sides: the back only stalls on a checksum
    // beat whose result register is still occupied.
    sfr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_beat  (push_beat),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (pop),
        .o_beat  (pop_beat)
    );

    // The back keeps the running sum, the reset-pattern match and the
    // payload bytes, and builds the result when the checksum beat arrives.
    sfr_back u_back (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cfg_we              (i_cfg_we),
        .i_cfg_wdata           (i_cfg_wdata),
        .i_q_valid             (q_valid),
        .i_beat                (pop_beat),
        .o_pop                 (pop),
        .o_res_valid           (o_res_valid),
        .i_res_ready           (i_res_ready),
        .o_status              (o_status),
        .o_velocity_valid      (o_velocity_valid),
        .o_forward_speed_bits  (o_forward_speed_bits),
        .o_sideways_speed_bits (o_sideways_speed_bits),
        .o_turn_rate_bits      (o_turn_rate_bits),
        .o_reset_request       (o_reset_request)
    );

endmodule

// ----- test/tb_top.sv -----
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sfr_pkg::*;

    // The run is short, so a generous ceiling only catches a stuck handshake.
    localparam int CYCLE_LIMIT   = 200000;
    // The result register sits behind a small internal queue, so the settle time
    // leaves a margin for a checksum beat still on its way through the block.
    localparam int SETTLE_CYCLES = 12;
    // An idle cycle on either side happens roughly 22 times in a hundred.
    localparam int IDLE_PERCENT  = 22;
    localparam int PHASE_BYTES   = 300;

    // This is the payload that raises the reset request, with byte 0 in the low bits.
    localparam logic [95:0] RESET_BODY = 96'hCCBB_AA99_8877_6655_4433_2211;

    typedef struct packed {
        logic        status;
        logic        velocity_valid;
        logic [31:0] forward_bits;
        logic [31:0] sideways_bits;
        logic [31:0] turn_bits;
        logic        reset_request;
    } t_frame_result;

    logic        i_clk                 = 1'b0;
    logic        i_rst_n               = 1'b0;
    logic        i_cfg_we              = 1'b0;
    logic        i_cfg_wdata           = 1'b0;
    logic        i_rx_valid            = 1'b0;
    logic [7:0]  i_rx_byte             = 8'h00;
    logic        i_res_ready           = 1'b0;
    logic        o_rx_ready;
    logic        o_res_valid;
    logic        o_status;
    logic        o_velocity_valid;
    logic [31:0] o_forward_speed_bits;
    logic [31:0] o_sideways_speed_bits;
    logic [31:0] o_turn_rate_bits;
    logic        o_reset_request;

    // The initial block fills this queue with serial bytes. The driver pops one
    // byte for each beat it offers.
    logic [7:0]    rx_bytes_pending [$];
    // These are the frame results worked out from accepted bytes, oldest first.
    t_frame_result frame_results_due [$];

    // This is the testbench's own copy of the receiver state and of the mode register.
    t_hunt      hunt          = HUNT_FIRST;
    logic [3:0] body_count    = 4'd0;
    logic [7:0] body_sum      = 8'h00;
    logic       body_is_reset = 1'b1;
    logic [7:0] frame_body [PAYLOAD_LEN];
    logic       control_mode  = 1'b0;

    // While this is set, neither side idles.
    bit no_idle_stretch = 1'b0;
    int mismatches      = 0;
    int cycle_count     = 0;

    sync_sum_frame_receiver dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cfg_we              (i_cfg_we),
        .i_cfg_wdata           (i_cfg_wdata),
        .i_rx_valid            (i_rx_valid),
        .o_rx_ready            (o_rx_ready),
        .i_rx_byte             (i_rx_byte),
        .o_res_valid           (o_res_valid),
        .i_res_ready           (i_res_ready),
        .o_status              (o_status),
        .o_velocity_valid      (o_velocity_valid),
        .o_forward_speed_bits  (o_forward_speed_bits),
        .o_sideways_speed_bits (o_sideways_speed_bits),
        .o_turn_rate_bits      (o_turn_rate_bits),
        .o_reset_request       (o_reset_request)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Each beat is folded into the frame state here. A checksum beat closes the
    // frame and leaves one expected result. The mode is taken as it stands when
    // the checksum beat is accepted.
    task automatic absorb_rx_byte(input logic [7:0] b);
        t_frame_result r;
        if (hunt == COLLECT) begin
            if (int'(body_count) < PAYLOAD_LEN) begin
                frame_body[body_count] = b;
                body_sum = body_sum + b;
                if (b != RESET_BODY[8*int'(body_count) +: 8]) begin
                    body_is_reset = 1'b0;
                end
                body_count = body_count + 4'd1;
            end else begin
                r = '0;
                r.status = (b != body_sum);
                r.velocity_valid = !r.status && control_mode;
                // The speed words are passed out only when they apply. Otherwise they are zero.
                if (r.velocity_valid) begin
                    r.forward_bits  = {frame_body[3], frame_body[2], frame_body[1], frame_body[0]};
                    r.sideways_bits = {frame_body[7], frame_body[6], frame_body[5], frame_body[4]};
                    r.turn_bits     = {frame_body[11], frame_body[10], frame_body[9], frame_body[8]};
                end
                r.reset_request = !r.status && body_is_reset;
                frame_results_due.push_back(r);
                hunt          = HUNT_FIRST;
                body_count    = 4'd0;
                body_sum      = 8'h00;
                body_is_reset = 1'b1;
            end
        end else if (hunt == HUNT_SECOND) begin
            // Any byte but the second sync byte drops the hunt, a repeated first one too.
            hunt = (b == SYNC_SECOND) ? COLLECT : HUNT_FIRST;
        end else begin
            hunt = (b == SYNC_FIRST) ? HUNT_SECOND : HUNT_FIRST;
        end
    endtask

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %h want %h", name, got, want));
        end
    endtask

    // The driver predicts each accepted beat first and only then decides on the
    // next beat. Valid is assigned once per edge, so a back-to-back beat never
    // sees valid lowered and raised in the same step.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_rx_valid <= 1'b0;
        end else begin
            if (i_rx_valid && o_rx_ready) begin
                absorb_rx_byte(i_rx_byte);
            end
            if (!i_rx_valid || o_rx_ready) begin
                if (rx_bytes_pending.size() > 0 &&
                    (no_idle_stretch || $urandom_range(99) >= IDLE_PERCENT)) begin
                    i_rx_byte  <= rx_bytes_pending.pop_front();
                    i_rx_valid <= 1'b1;
                end else begin
                    i_rx_valid <= 1'b0;
                end
            end
        end
    end

    // The monitor checks every accepted result against the oldest expectation.
    // It also stalls the result channel at random.
    always @(posedge i_clk) begin
        t_frame_result want;
        if (i_rst_n && o_res_valid && i_res_ready) begin
            if (frame_results_due.size() == 0) begin
                report_mismatch("result beat with no frame pending");
            end else begin
                want = frame_results_due.pop_front();
                check_field("status", 32'(o_status), 32'(want.status));
                check_field("velocity_valid", 32'(o_velocity_valid), 32'(want.velocity_valid));
                check_field("forward_speed_bits", o_forward_speed_bits, want.forward_bits);
                check_field("sideways_speed_bits", o_sideways_speed_bits, want.sideways_bits);
                check_field("turn_rate_bits", o_turn_rate_bits, want.turn_bits);
                check_field("reset_request", 32'(o_reset_request), 32'(want.reset_request));
            end
        end
        i_res_ready <= no_idle_stretch || ($urandom_range(99) >= IDLE_PERCENT);
    end

    // A stuck handshake ends the run here.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("== FAIL ==");
            $finish;
        end
    end

    // This queues a full frame: both sync bytes, the payload and its checksum.
    // A spoiled frame gets a checksum that is off by a nonzero amount.
    task automatic queue_frame(input logic [95:0] payload, input bit spoil);
        logic [7:0] sum;
        sum = 8'h00;
        rx_bytes_pending.push_back(SYNC_FIRST);
        rx_bytes_pending.push_back(SYNC_SECOND);
        for (int i = 0; i < PAYLOAD_LEN; i++) begin
            rx_bytes_pending.push_back(payload[8*i +: 8]);
            sum = sum + payload[8*i +: 8];
        end
        if (spoil) begin
            sum = sum + 8'($urandom_range(255, 1));
        end
        rx_bytes_pending.push_back(sum);
    endtask

    // Most of the traffic is whole frames with random content. The rest is line
    // noise, broken headers and frames cut short, which makes the following
    // header bytes land inside the payload.
    task automatic queue_random_traffic(input int budget);
        int          pick;
        logic [95:0] payload;
        logic [7:0]  b;
        while (rx_bytes_pending.size() < budget) begin
            pick = $urandom_range(99);
            if (pick < 10) begin
                repeat ($urandom_range(4, 1)) rx_bytes_pending.push_back(8'($urandom));
            end else if (pick < 16) begin
                // A first sync byte followed by anything but the second one.
                b = 8'($urandom);
                rx_bytes_pending.push_back(SYNC_FIRST);
                rx_bytes_pending.push_back((b == SYNC_SECOND) ? SYNC_FIRST : b);
                if ($urandom_range(1)) begin
                    rx_bytes_pending.push_back(SYNC_SECOND);
                end
            end else if (pick < 20) begin
                rx_bytes_pending.push_back(SYNC_FIRST);
                rx_bytes_pending.push_back(SYNC_SECOND);
                repeat ($urandom_range(PAYLOAD_LEN - 1, 1)) begin
                    rx_bytes_pending.push_back(8'($urandom));
                end
            end else begin
                case ($urandom_range(9))
                    0:       payload = '0;
                    1:       payload = '1;
                    2:       payload = RESET_BODY;
                    3:       payload = RESET_BODY ^ (96'(8'($urandom_range(255, 1)))
                                                     << (8 * $urandom_range(PAYLOAD_LEN - 1)));
                    default: payload = {$urandom, $urandom, $urandom};
                endcase
                queue_frame(payload, $urandom_range(99) < 25);
            end
        end
    endtask

    // Nothing else is sent until every queued byte has gone and every expected
    // result has arrived. The settle time covers a last frame that is still
    // in flight inside the block.
    task automatic wait_until_quiet();
        while (rx_bytes_pending.size() != 0 || i_rx_valid || frame_results_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // The mode is only written while the block is idle, so the local copy can
    // follow it at once.
    task automatic write_control_mode(input logic mode);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= mode;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        control_mode = mode;
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // The directed part covers the byte extremes and a broken header in which
        // a repeated first sync byte must not restart the hunt. The 0x55 after it
        // is then only noise. It ends with the reset pattern as a good frame
        // while velocity commands are accepted.
        write_control_mode(1'b1);
        @(negedge i_clk);
        rx_bytes_pending.push_back(8'h00);
        rx_bytes_pending.push_back(8'hFF);
        rx_bytes_pending.push_back(SYNC_FIRST);
        rx_bytes_pending.push_back(SYNC_FIRST);
        rx_bytes_pending.push_back(SYNC_SECOND);
        queue_frame(RESET_BODY, 1'b0);
        wait_until_quiet();

        // The random phases alternate the mode. One phase runs with no idling at all.
        for (int phase = 0; phase < 5; phase++) begin
            write_control_mode(phase[0]);
            @(negedge i_clk);
            no_idle_stretch = (phase == 3);
            queue_random_traffic(PHASE_BYTES);
            wait_until_quiet();
            no_idle_stretch = 1'b0;
        end

        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ----- sync_sum_frame_receiver.f -----
rtl/sfr_pkg.sv
rtl/sfr_front.sv
rtl/sfr_queue.sv
rtl/sfr_back.sv
rtl/sync_sum_frame_receiver.sv
test/tb_top.sv
